// ===== hdl/scc_pkg.sv =====
// scc_pkg: shared types and constants for the strongly connected component counter
// no dependencies
`timescale 1ns / 1ps
package scc_pkg;
	localparam int MaxVertices = 32;
	localparam int VW = 5;
	localparam int CW = 6;

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_ADD   = 2'd1,
		MODE_COUNT = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_P1_START,
		ST_P1_SCAN,
		ST_P2_START,
		ST_P2_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear_adj;
		logic add_edge;
		logic init_p1;
		logic p1_start;
		logic p1_scan;
		logic init_p2;
		logic p2_start;
		logic p2_scan;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic p1_all_done;
		logic p1_need_start;
		logic stack_empty;
		logic p2_order_empty;
		logic p2_need_start;
	} status_t;
endpackage

// ===== hdl/scc_datapath.sv =====
// scc_datapath: adjacency matrix, visited marks, stack, finish order and tally
// depends on scc_pkg
`timescale 1ns / 1ps
module scc_datapath import scc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic [CW-1:0]     vertex_count,
	input  logic [VW-1:0]     source_vertex,
	input  logic [VW-1:0]     target_vertex,
	output status_t           status,
	output logic [CW-1:0]     tally
);
	logic [MaxVertices-1:0] adj_q [MaxVertices];
	logic [MaxVertices-1:0] visited_q;
	logic [VW-1:0] order_q [MaxVertices];
	logic [VW-1:0] stack_q [MaxVertices];
	logic [CW-1:0] depth_q, fin_q, tally_q, next_q;
	logic [CW-1:0] n;
	logic [VW-1:0] top, cand, pick;
	logic [MaxVertices-1:0] row, avail, limit;
	logic found;

	assign n = (vertex_count > CW'(MaxVertices)) ? CW'(MaxVertices) : vertex_count;
	assign top = (depth_q == '0) ? '0 : stack_q[VW'(depth_q - 1'b1)];
	assign cand = order_q[VW'(fin_q - 1'b1)];

	always_comb begin
		for (int i = 0; i < MaxVertices; i++) begin
			limit[i] = (CW'(i) < n);
			row[i] = cmd.p2_scan ? adj_q[i][top] : adj_q[top][i];
		end
		avail = row & ~visited_q & limit;
		found = |avail;
		pick = '0;
		for (int i = MaxVertices - 1; i >= 0; i--) begin
			if (avail[i]) begin
				pick = VW'(i);
			end
		end
	end

	always_comb begin
		status.p1_all_done = (next_q >= n);
		status.p1_need_start = !visited_q[VW'(next_q)];
		status.stack_empty = (depth_q == '0);
		status.p2_order_empty = (fin_q == '0);
		status.p2_need_start = (CW'(cand) < n) && !visited_q[cand];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxVertices; i++) begin
				adj_q[i] <= '0;
			end
			visited_q <= '0;
			depth_q <= '0;
			fin_q <= '0;
			tally_q <= '0;
			next_q <= '0;
		end else begin
			if (cmd.clear_adj) begin
				for (int i = 0; i < MaxVertices; i++) begin
					adj_q[i] <= '0;
				end
			end
			if (cmd.add_edge && CW'(source_vertex) < n && CW'(target_vertex) < n) begin
				adj_q[source_vertex][target_vertex] <= 1'b1;
			end
			if (cmd.init_p1) begin
				visited_q <= '0;
				fin_q <= '0;
				next_q <= '0;
				depth_q <= '0;
			end
			if (cmd.p1_start) begin
				if (status.p1_need_start) begin
					visited_q[VW'(next_q)] <= 1'b1;
					stack_q[0] <= VW'(next_q);
					depth_q <= CW'(1);
				end
				next_q <= next_q + 1'b1;
			end
			if (cmd.p1_scan || cmd.p2_scan) begin
				if (found) begin
					visited_q[pick] <= 1'b1;
					stack_q[VW'(depth_q)] <= pick;
					depth_q <= depth_q + 1'b1;
				end else begin
					depth_q <= depth_q - 1'b1;
					if (cmd.p1_scan) begin
						order_q[VW'(fin_q)] <= top;
						fin_q <= fin_q + 1'b1;
					end
				end
			end
			if (cmd.init_p2) begin
				visited_q <= '0;
				tally_q <= '0;
			end
			if (cmd.p2_start) begin
				if (status.p2_need_start) begin
					visited_q[cand] <= 1'b1;
					stack_q[0] <= cand;
					depth_q <= CW'(1);
					tally_q <= tally_q + 1'b1;
				end
				fin_q <= fin_q - 1'b1;
			end
		end
	end

	assign tally = tally_q;
endmodule

// ===== hdl/scc_controller.sv =====
// scc_controller: sequences the two search passes and the handshakes
// depends on scc_pkg
`timescale 1ns / 1ps
module scc_controller import scc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_fire,
	input  mode_t    in_mode,
	input  logic     out_busy,
	input  status_t  status,
	output logic     in_ready,
	output cmd_t     cmd
);
	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_fire && in_mode == MODE_COUNT) state_d = ST_P1_START;
			ST_P1_START: begin
				if (status.p1_all_done) state_d = ST_P2_START;
				else if (status.p1_need_start) state_d = ST_P1_SCAN;
			end
			ST_P1_SCAN: if (status.stack_empty) state_d = ST_P1_START;
			ST_P2_START: begin
				if (status.p2_order_empty) state_d = ST_DONE;
				else if (status.p2_need_start) state_d = ST_P2_SCAN;
			end
			ST_P2_SCAN: if (status.stack_empty) state_d = ST_P2_START;
			ST_DONE: if (!out_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.clear_adj = in_fire && in_mode == MODE_CLEAR;
				cmd.add_edge = in_fire && in_mode == MODE_ADD;
				cmd.init_p1 = in_fire && in_mode == MODE_COUNT;
			end
			ST_P1_START: begin
				cmd.p1_start = !status.p1_all_done;
				cmd.init_p2 = status.p1_all_done;
			end
			ST_P1_SCAN: cmd.p1_scan = !status.stack_empty;
			ST_P2_START: cmd.p2_start = !status.p2_order_empty;
			ST_P2_SCAN: cmd.p2_scan = !status.stack_empty;
			ST_DONE: cmd.load_out = !out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end
endmodule

// ===== hdl/strongly_connected_component_counter.sv =====
// strongly_connected_component_counter: top level, config register and output register
// depends on scc_pkg, scc_controller, scc_datapath
`timescale 1ns / 1ps
// usage:
// cfg_valid/cfg_ready write vertex_count; write only while idle.
// in_valid/in_ready carry mode, source_vertex, target_vertex.
// clear and add-edge items give no result; one per cycle while no count is running.
// a count item walks the adjacency matrix with an explicit stack in a
// depth-first search over both passes, with n the vertex count capped at 32.
// intake is held off until the count ends and its result is loaded.
// out_valid/out_ready carry component_count and strongly_connected from
// an output register; while a result waits, edge items are still taken,
// but the next count holds before loading until the output is free.
// reset clears the matrix, vertex_count and all control state.
module strongly_connected_component_counter import scc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [CW-1:0] vertex_count,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    mode,
	input  logic [VW-1:0] source_vertex,
	input  logic [VW-1:0] target_vertex,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [CW-1:0] component_count,
	output logic          strongly_connected
);
	logic [CW-1:0] vcount_q;
	logic out_valid_q;
	logic [CW-1:0] count_q;
	logic tally_one_q;
	cmd_t cmd;
	status_t status;
	logic [CW-1:0] tally;
	logic in_fire;

	assign cfg_ready = 1'b1;
	assign in_fire = in_valid && in_ready;

	scc_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_mode(mode_t'(mode)),
		.out_busy(out_valid_q && !out_ready), .status(status),
		.in_ready(in_ready), .cmd(cmd)
	);

	scc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .vertex_count(vcount_q),
		.source_vertex(source_vertex), .target_vertex(target_vertex),
		.status(status), .tally(tally)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) vcount_q <= vertex_count;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			count_q <= tally;
			tally_one_q <= (tally == CW'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign component_count = count_q;
	assign strongly_connected = tally_one_q;
endmodule
